// ===== src/vde_pkg.sv =====
`default_nettype none
package vde_pkg;

  // request kinds on s_tuser
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_PLAY = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LEVEL_TARGET = 2'd0;
  localparam logic [1:0] CFG_SMOOTH_COEFF = 2'd1;
  localparam logic [1:0] CFG_DECLICK_STEP = 2'd2;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int GAIN_FRAC_BITS_DEF = 24;

  // level is Q4.20, voice gain Q5.24
  localparam int LEVEL_W    = 24;
  localparam int LEVEL_FRAC = 20;
  localparam int VGAIN_FRAC = 24;
  localparam int VG_W       = 29;
  localparam int DELTA_W    = LEVEL_W + 1;
  localparam int MOVE_W     = LEVEL_W + 2;

  localparam logic [LEVEL_W-1:0] LEVEL_TARGET_RST = 24'd1048576;
  localparam int SMOOTH_COEFF_RST = 34914;
  localparam int DECLICK_STEP_RST = 69905;

endpackage
`default_nettype wire

// ===== src/voice_declick_envelope.sv =====
`default_nettype none
// channel  dir  handshake         payload
// s        in   s_tvalid/tready   tdata: in_left, in_right; tuser: req_type, source_missing
// m        out  m_tvalid/tready   tdata: out_left, out_right; tuser: is_sounding, restart
// cfg      in   cfg_we            cfg_index, cfg_data
//
// Play, stop, an idle tick or a missing source go from accept straight to the output.
// A sounding tick first has one shared signed multiplier run four products in turn
// (smoother, envelope times level, left, right), each registered before use.
// s_tready is high only while the sequencer is idle. A stalled m side holds the
// finished word; the next word is still taken and waits before loading the output.
// rst (synchronous) clears voice state and restores the register defaults.
module voice_declick_envelope #(
  parameter int SAMPLE_BITS    = vde_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = vde_pkg::GAIN_FRAC_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int GW    = GAIN_FRAC_BITS + 1,
  localparam int CFG_W = (GW > vde_pkg::LEVEL_W) ? GW : vde_pkg::LEVEL_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // in_left, in_right, zero pad
  input  wire logic [2:0]       s_tuser,   // req_type[1:0], source_missing
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [IN_W-1:0]       m_tdata,   // out_left, out_right, zero pad
  output logic [1:0]            m_tuser,   // is_sounding, restart_playhead
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int G  = GAIN_FRAC_BITS;
  localparam int LW = vde_pkg::LEVEL_W;
  localparam int MA = (SB > vde_pkg::DELTA_W) ? SB : vde_pkg::DELTA_W;
  localparam int MB = ((G + 2) > (vde_pkg::VG_W + 1)) ? (G + 2) : (vde_pkg::VG_W + 1);
  localparam int PW = MA + MB;
  localparam int VG_SHIFT = G + vde_pkg::LEVEL_FRAC - vde_pkg::VGAIN_FRAC;

  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {G{1'b0}}};
  localparam logic [GW-1:0] STEP_MIN = {{G{1'b0}}, 1'b1};
  localparam logic signed [PW-1:0] ONE_P   = {{(PW-1){1'b0}}, 1'b1};
  localparam logic signed [PW-1:0] HALF_SM = ONE_P <<< (G - 1);
  localparam logic signed [PW-1:0] HALF_VG = ONE_P <<< (VG_SHIFT - 1);
  localparam logic signed [PW-1:0] HALF_S  = ONE_P <<< (vde_pkg::VGAIN_FRAC - 1);
  localparam logic signed [PW-1:0] SMAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SMOOTH = 4'd1;
  localparam logic [3:0] ST_LEVEL  = 4'd2;
  localparam logic [3:0] ST_VGAIN  = 4'd3;
  localparam logic [3:0] ST_VROUND = 4'd4;
  localparam logic [3:0] ST_MUL_L  = 4'd5;
  localparam logic [3:0] ST_MUL_R  = 4'd6;
  localparam logic [3:0] ST_FIN    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state;

  logic [LW-1:0] level_target;
  logic [GW-1:0] smooth_coeff;
  logic [GW-1:0] declick_step;

  logic          sounding;
  logic          stopping;
  logic [GW-1:0] env_gain;
  logic [LW-1:0] level_gain;
  logic          level_snap;
  logic          level_apply;

  logic signed [SB-1:0] smp_left;
  logic signed [SB-1:0] smp_right;
  logic signed [SB-1:0] res_left;
  logic signed [SB-1:0] res_right;
  logic                 res_restart;
  logic [vde_pkg::VG_W-1:0] vgain;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic [GW-1:0]        coeff_sat;
  logic [GW-1:0]        step_eff;
  logic signed [vde_pkg::DELTA_W-1:0] delta;
  logic signed [PW-1:0] sm_round;
  logic signed [vde_pkg::MOVE_W-1:0] move;
  logic signed [vde_pkg::MOVE_W-1:0] level_sum;
  logic signed [GW:0]   env_dn;
  logic [GW:0]          env_up;
  logic signed [PW-1:0] vg_round;
  logic signed [PW-1:0] smp_round;
  logic signed [SB-1:0] smp_sat;

  logic [1:0] in_req;
  logic       in_missing;

  assign s_tready   = (state == ST_IDLE);
  assign in_req     = s_tuser[1:0];
  assign in_missing = s_tuser[2];

  always_comb begin
    coeff_sat = (smooth_coeff > GAIN_ONE) ? GAIN_ONE : smooth_coeff;
    step_eff  = (declick_step == '0) ? STEP_MIN : declick_step;
    delta     = $signed({1'b0, level_target}) - $signed({1'b0, level_gain});
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_SMOOTH: begin
        mul_a = MA'(delta);
        mul_b = $signed(MB'(coeff_sat));
      end
      ST_VGAIN: begin
        mul_a = $signed(MA'(level_gain));
        mul_b = $signed(MB'(env_gain));
      end
      ST_MUL_R: begin
        mul_a = MA'(smp_right);
        mul_b = $signed(MB'(vgain));
      end
      default: begin
        mul_a = MA'(smp_left);
        mul_b = $signed(MB'(vgain));
      end
    endcase
  end

  // rounding: add half, arithmetic shift (ties upward)
  always_comb begin
    sm_round = (prod + HALF_SM) >>> G;
    move     = sm_round[vde_pkg::MOVE_W-1:0];
    if (move == '0 && delta != '0) begin
      move = delta[vde_pkg::DELTA_W-1] ? -vde_pkg::MOVE_W'(1) : vde_pkg::MOVE_W'(1);
    end
    level_sum = $signed({2'b00, level_gain}) + move;
    vg_round  = (prod + HALF_VG) >>> VG_SHIFT;
    smp_round = (prod + HALF_S) >>> vde_pkg::VGAIN_FRAC;
    if (smp_round > SMAX) begin
      smp_sat = SMAX[SB-1:0];
    end else if (smp_round < SMIN) begin
      smp_sat = SMIN[SB-1:0];
    end else begin
      smp_sat = smp_round[SB-1:0];
    end
    env_dn = $signed({1'b0, env_gain}) - $signed({1'b0, step_eff});
    env_up = {1'b0, env_gain} + {1'b0, step_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      level_target <= vde_pkg::LEVEL_TARGET_RST;
      smooth_coeff <= GW'(vde_pkg::SMOOTH_COEFF_RST);
      declick_step <= GW'(vde_pkg::DECLICK_STEP_RST);
      sounding     <= 1'b0;
      stopping     <= 1'b0;
      env_gain     <= '0;
      level_gain   <= '0;
      level_snap   <= 1'b1;
      level_apply  <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vde_pkg::CFG_LEVEL_TARGET: level_target <= cfg_data[LW-1:0];
          vde_pkg::CFG_SMOOTH_COEFF: smooth_coeff <= cfg_data[GW-1:0];
          vde_pkg::CFG_DECLICK_STEP: declick_step <= cfg_data[GW-1:0];
          default: ;
        endcase
      end

      // ST_OUT reloads the output itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            smp_left    <= $signed(s_tdata[SB-1:0]);
            smp_right   <= $signed(s_tdata[2*SB-1:SB]);
            res_left    <= '0;
            res_right   <= '0;
            res_restart <= (in_req == vde_pkg::REQ_PLAY) && !sounding;
            state       <= (in_req == vde_pkg::REQ_TICK && sounding && !in_missing) ?
                           ST_SMOOTH : ST_OUT;
            case (in_req)
              vde_pkg::REQ_PLAY: begin
                stopping <= 1'b0;
                if (!sounding) begin
                  sounding   <= 1'b1;
                  env_gain   <= '0;
                  level_snap <= 1'b1;
                end
              end
              vde_pkg::REQ_STOP: begin
                if (sounding) begin
                  stopping <= 1'b1;
                end
              end
              vde_pkg::REQ_TICK: begin
                if (sounding && in_missing) begin
                  sounding <= 1'b0;
                  stopping <= 1'b0;
                  env_gain <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SMOOTH: begin
          prod        <= mul_a * mul_b;
          level_apply <= !level_snap && (coeff_sat != '0);
          if (level_snap) begin
            level_gain <= level_target;
            level_snap <= 1'b0;
          end
          // envelope reads only its own state, so it steps alongside the smoother
          if (stopping) begin
            if (env_dn <= 0) begin
              env_gain <= '0;
              sounding <= 1'b0;
              stopping <= 1'b0;
            end else begin
              env_gain <= env_dn[GW-1:0];
            end
          end else if (env_gain < GAIN_ONE) begin
            env_gain <= (env_up > {1'b0, GAIN_ONE}) ? GAIN_ONE : env_up[GW-1:0];
          end
          state <= ST_LEVEL;
        end
        ST_LEVEL: begin
          if (level_apply) begin
            level_gain <= level_sum[LW-1:0];
          end
          state <= ST_VGAIN;
        end
        ST_VGAIN: begin
          prod  <= mul_a * mul_b;
          state <= ST_VROUND;
        end
        ST_VROUND: begin
          vgain <= vg_round[vde_pkg::VG_W-1:0];
          state <= ST_MUL_L;
        end
        ST_MUL_L: begin
          prod  <= mul_a * mul_b;
          state <= ST_MUL_R;
        end
        ST_MUL_R: begin
          res_left <= sounding ? smp_sat : '0;
          prod     <= mul_a * mul_b;
          state    <= ST_FIN;
        end
        ST_FIN: begin
          res_right <= sounding ? smp_sat : '0;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= IN_W'({res_right, res_left});
            m_tuser  <= {res_restart, sounding};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
